[hw/rtl/nap_pkg.sv]
// Shared types and constants of the NAT address pool allocator.
// Request and response payloads, controller command and status bundles.
// No dependencies.
`default_nettype none

package nap_pkg;

	localparam int ADDR_W      = 32;
	localparam int COUNT_W     = 9;
	localparam int STATUS_W    = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int WORD_BITS   = 32;
	localparam int BIT_W       = 5;
	localparam int START_W     = 11;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_IN_POOL = 2'd2;

	localparam logic CFG_KIND_BASE  = 1'b0;
	localparam logic CFG_KIND_COUNT = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [ADDR_W-1:0] address;
	} nap_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   granted_address;
		logic [COUNT_W-1:0]  addresses_used;
	} nap_rsp_t;

	typedef struct packed {
		logic                accept;
		logic                scan_init;
		logic                scan_step;
		logic                map_init;
		logic                map_step;
		logic                free_read;
		logic                set_bit;
		logic                clear_bit;
		logic                sweep_step;
		logic                rsp_load;
		logic [STATUS_W-1:0] rsp_status;
	} nap_cmd_t;

	typedef struct packed {
		logic req_free;
		logic total_zero;
		logic scan_valid;
		logic scan_found;
		logic scan_last;
		logic map_hit;
		logic map_last;
		logic free_oob;
		logic bit_set;
		logic sweep_done;
	} nap_sts_t;

endpackage

`default_nettype wire

[hw/rtl/nap_dpath.sv]
// Datapath of the NAT address pool allocator: range registers, in-use
// bitmap memory, first-free scan, range mapping and response register.
// Depends on nap_pkg.
`default_nettype none

module nap_dpath #(
	parameter int POOL_SIZE   = 256,
	parameter int RANGE_SLOTS = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [nap_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [nap_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire nap_pkg::nap_req_t                req,
	input  wire nap_pkg::nap_cmd_t                cmd,
	output nap_pkg::nap_sts_t                     sts,
	output nap_pkg::nap_rsp_t                     rsp
);

	import nap_pkg::*;

	localparam int ROWS   = (POOL_SIZE + WORD_BITS - 1) / WORD_BITS;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int GIDX_W = ROW_W + BIT_W;
	localparam int TOT_W  = $clog2(POOL_SIZE + 1);
	localparam int K_W    = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
	localparam int MW     = ((GIDX_W > START_W) ? GIDX_W : START_W) + 2;

	logic [ADDR_W-1:0]    base_q [RANGE_SLOTS];
	logic [COUNT_W-1:0]   count_q [RANGE_SLOTS];

	logic [WORD_BITS-1:0] mem [ROWS];
	logic [WORD_BITS-1:0] rd_data_s1;
	logic [ROW_W-1:0]     data_row_s1;
	logic                 data_vld_s1;
	logic [ROW_W-1:0]     row_q;
	logic [ROW_W-1:0]     sweep_q;
	logic [ROW_W-1:0]     last_row_q;
	logic [BIT_W-1:0]     last_bit_q;
	logic [K_W-1:0]       k_q;
	logic [START_W-1:0]   start_q;
	logic [GIDX_W-1:0]    idx_q;
	logic [TOT_W-1:0]     used_q;
	logic                 op_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [ADDR_W-1:0]    grant_q;
	nap_rsp_t             rsp_q;

	logic [MW-1:0]        sum;
	logic [TOT_W-1:0]     sat_total;
	logic [GIDX_W-1:0]    tm1;
	logic [WORD_BITS-1:0] thermo;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] free_bits;
	logic [BIT_W-1:0]     hit_bit;
	logic [ADDR_W-1:0]    base_k;
	logic [COUNT_W-1:0]   count_k;
	logic                 alloc_hit;
	logic [MW-1:0]        alloc_off;
	logic [ADDR_W-1:0]    off;
	logic                 free_hit;
	logic [MW-1:0]        free_gidx;
	logic [ROW_W-1:0]     idx_row;
	logic [WORD_BITS-1:0] idx_onehot;
	logic                 mem_we;
	logic                 mem_rd;
	logic [ROW_W-1:0]     wr_row;
	logic [ROW_W-1:0]     rd_row;
	logic [WORD_BITS-1:0] wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < RANGE_SLOTS; s++) begin
				base_q[s]  <= '0;
				count_q[s] <= '0;
			end
		end else if (cfg_write) begin
			for (int s = 0; s < RANGE_SLOTS; s++) begin
				if (cfg_index[CFG_INDEX_W-1:1] == (CFG_INDEX_W-1)'(s)) begin
					if (cfg_index[0] == CFG_KIND_BASE) begin
						base_q[s] <= cfg_data[ADDR_W-1:0];
					end else begin
						count_q[s] <= cfg_data[COUNT_W-1:0];
					end
				end
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int s = 0; s < RANGE_SLOTS; s++) begin
			sum = sum + MW'(count_q[s]);
		end
		if (sum >= MW'(POOL_SIZE)) begin
			sat_total = TOT_W'(POOL_SIZE);
		end else begin
			sat_total = TOT_W'(sum);
		end
		tm1 = GIDX_W'(sat_total - TOT_W'(1));
	end

	always_comb begin
		thermo = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - last_bit_q);
		if (data_row_s1 < last_row_q) begin
			mask = '1;
		end else if (data_row_s1 == last_row_q) begin
			mask = thermo;
		end else begin
			mask = '0;
		end
		free_bits = ~rd_data_s1 & mask;
		hit_bit   = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				hit_bit = BIT_W'(b);
			end
		end
	end

	always_comb begin
		base_k     = base_q[k_q];
		count_k    = count_q[k_q];
		alloc_hit  = MW'(idx_q) < (MW'(start_q) + MW'(count_k));
		alloc_off  = MW'(idx_q) - MW'(start_q);
		off        = addr_q - base_k;
		free_hit   = off < ADDR_W'(count_k);
		free_gidx  = MW'(start_q) + MW'(off[COUNT_W-1:0]);
		idx_row    = idx_q[GIDX_W-1:BIT_W];
		idx_onehot = WORD_BITS'(1) << idx_q[BIT_W-1:0];
	end

	always_comb begin
		mem_rd  = cmd.scan_step | cmd.free_read;
		rd_row  = cmd.free_read ? idx_row : row_q;
		mem_we  = cmd.sweep_step | cmd.set_bit | cmd.clear_bit;
		wr_row  = cmd.sweep_step ? sweep_q : idx_row;
		if (cmd.set_bit) begin
			wr_data = rd_data_s1 | idx_onehot;
		end else if (cmd.clear_bit) begin
			wr_data = rd_data_s1 & ~idx_onehot;
		end else begin
			wr_data = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_row] <= wr_data;
		end
		if (mem_rd) begin
			rd_data_s1 <= mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			data_row_s1 <= '0;
			data_vld_s1 <= 1'b0;
			sweep_q     <= '0;
			k_q         <= '0;
			start_q     <= '0;
			used_q      <= '0;
		end else begin
			if (cmd.scan_init) begin
				row_q       <= '0;
				data_vld_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				if (row_q != ROW_W'(ROWS - 1)) begin
					row_q <= row_q + ROW_W'(1);
				end
				data_row_s1 <= row_q;
				data_vld_s1 <= 1'b1;
			end
			if (cmd.sweep_step && !sts.sweep_done) begin
				sweep_q <= sweep_q + ROW_W'(1);
			end
			if (cmd.accept || cmd.map_init) begin
				k_q     <= '0;
				start_q <= '0;
			end else if (cmd.map_step && !sts.map_hit && !sts.map_last) begin
				k_q     <= k_q + K_W'(1);
				start_q <= START_W'(start_q + START_W'(count_k));
			end
			if (cmd.set_bit) begin
				used_q <= used_q + TOT_W'(1);
			end else if (cmd.clear_bit) begin
				used_q <= used_q - TOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= req.operation;
			addr_q  <= req.address;
			grant_q <= '0;
		end
		if (cmd.scan_init) begin
			last_row_q <= tm1[GIDX_W-1:BIT_W];
			last_bit_q <= tm1[BIT_W-1:0];
		end
		if (cmd.map_init) begin
			idx_q <= {data_row_s1, hit_bit};
		end else if (cmd.map_step && sts.map_hit) begin
			if (op_q == OP_FREE) begin
				idx_q <= GIDX_W'(free_gidx);
			end else begin
				grant_q <= base_k + ADDR_W'(alloc_off);
			end
		end
		if (cmd.rsp_load) begin
			rsp_q.status          <= cmd.rsp_status;
			rsp_q.granted_address <= grant_q;
			rsp_q.addresses_used  <= COUNT_W'(used_q);
		end
	end

	always_comb begin
		sts.req_free   = req.operation == OP_FREE;
		sts.total_zero = sat_total == '0;
		sts.scan_valid = data_vld_s1;
		sts.scan_found = |free_bits;
		sts.scan_last  = data_row_s1 == last_row_q;
		sts.map_hit    = (op_q == OP_FREE) ? free_hit : alloc_hit;
		sts.map_last   = k_q == K_W'(RANGE_SLOTS - 1);
		sts.free_oob   = free_gidx >= MW'(POOL_SIZE);
		sts.bit_set    = rd_data_s1[idx_q[BIT_W-1:0]];
		sts.sweep_done = sweep_q == ROW_W'(ROWS - 1);
	end

	assign rsp = rsp_q;

	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= TOT_W'(POOL_SIZE))
		else $error("used count above pool size");

	a_set_was_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_bit |-> !rd_data_s1[idx_q[BIT_W-1:0]])
		else $error("allocating an address already in use");

	a_clear_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_bit |-> used_q != '0)
		else $error("freeing with zero used count");

endmodule

`default_nettype wire

[hw/rtl/nap_ctrl.sv]
// Controller of the NAT address pool allocator: sequences the bitmap
// clearing pass, the allocate and free steps and the response handoff.
// Depends on nap_pkg.
`default_nettype none

module nap_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	input  wire nap_pkg::nap_sts_t  sts,
	output nap_pkg::nap_cmd_t       cmd
);

	import nap_pkg::*;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_ATOTAL,
		S_ASCAN,
		S_AMAP,
		S_ASET,
		S_FMAP,
		S_FREAD,
		S_FCHECK,
		S_RESULT
	} state_t;

	state_t              state_q;
	state_t              state_d;
	logic [STATUS_W-1:0] status_q;
	logic [STATUS_W-1:0] status_d;
	logic                rsp_valid_q;
	logic                rsp_valid_d;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		status_d    = status_q;
		rsp_valid_d = rsp_valid_q;
		if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_d = 1'b0;
		end
		case (state_q)
			S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.req_free ? S_FMAP : S_ATOTAL;
				end
			end
			S_ATOTAL: begin
				cmd.scan_init = 1'b1;
				if (sts.total_zero) begin
					status_d = ST_EXHAUSTED;
					state_d  = S_RESULT;
				end else begin
					state_d = S_ASCAN;
				end
			end
			S_ASCAN: begin
				if (sts.scan_valid && sts.scan_found) begin
					cmd.map_init = 1'b1;
					state_d      = S_AMAP;
				end else if (sts.scan_valid && sts.scan_last) begin
					status_d = ST_EXHAUSTED;
					state_d  = S_RESULT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_AMAP: begin
				cmd.map_step = 1'b1;
				if (sts.map_hit) begin
					state_d = S_ASET;
				end else if (sts.map_last) begin
					status_d = ST_EXHAUSTED;
					state_d  = S_RESULT;
				end
			end
			S_ASET: begin
				cmd.set_bit = 1'b1;
				status_d    = ST_OK;
				state_d     = S_RESULT;
			end
			S_FMAP: begin
				cmd.map_step = 1'b1;
				if (sts.map_hit) begin
					if (sts.free_oob) begin
						status_d = ST_NOT_IN_POOL;
						state_d  = S_RESULT;
					end else begin
						state_d = S_FREAD;
					end
				end else if (sts.map_last) begin
					status_d = ST_NOT_IN_POOL;
					state_d  = S_RESULT;
				end
			end
			S_FREAD: begin
				cmd.free_read = 1'b1;
				state_d       = S_FCHECK;
			end
			S_FCHECK: begin
				cmd.clear_bit = sts.bit_set;
				status_d      = ST_OK;
				state_d       = S_RESULT;
			end
			S_RESULT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.rsp_load   = 1'b1;
					cmd.rsp_status = status_q;
					rsp_valid_d    = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			status_q    <= ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			status_q    <= status_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;

	a_one_mem_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sweep_step, cmd.set_bit, cmd.clear_bit, cmd.scan_step, cmd.free_read}))
		else $error("more than one bitmap access in a cycle");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q != S_IDLE)
		else $error("request accepted but controller stayed idle");

endmodule

`default_nettype wire

[hw/rtl/nat_address_pool_allocator.sv]
// Top level of the NAT address pool allocator: controller plus datapath.
// Depends on nap_pkg, nap_ctrl and nap_dpath.
//
// Hands out IPv4 addresses from up to four configured ranges laid end to end
// in one in-use bitmap, stored as 32-bit rows in a single-port memory. One
// request is worked on at a time. An allocate scans the bitmap rows for
// the first free bit (one row per cycle, at most ceil(POOL_SIZE/32), eight
// by default), steps through the ranges (one per cycle, at most
// RANGE_SLOTS) to map it to an address and sets the bit; an empty pool or
// a search that finds no free address answers exhausted. A free steps
// through the ranges, reads the bitmap row and clears the bit if it is set,
// or answers not in pool. A response waits while an earlier one is still
// stalled, and the next request is taken in the cycle after the response is
// loaded. The rate is set by the row scan of the bitmap memory. After reset
// a clearing pass writes zero to every row, during which no request is
// accepted; configuration writes are taken at any time but must only be
// issued while the block is idle.
`default_nettype none

module nat_address_pool_allocator #(
	parameter int POOL_SIZE   = 256,
	parameter int RANGE_SLOTS = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [nap_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [nap_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire nap_pkg::nap_req_t               req,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output nap_pkg::nap_rsp_t                    rsp
);

	import nap_pkg::*;

	nap_cmd_t cmd;
	nap_sts_t sts;

	nap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	nap_dpath #(
		.POOL_SIZE   (POOL_SIZE),
		.RANGE_SLOTS (RANGE_SLOTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
